@@ rtl/pbfe_pkg.sv @@
// types and constants shared by the protobuf field encoder pipeline
// no dependencies
`default_nettype none

package pbfe_pkg;

	// request kinds carried on s_tuser
	localparam logic [2:0] KIND_VARINT  = 3'd0;
	localparam logic [2:0] KIND_SVARINT = 3'd1;
	localparam logic [2:0] KIND_FIX32   = 3'd2;
	localparam logic [2:0] KIND_FIX64   = 3'd3;
	localparam logic [2:0] KIND_HEADER  = 3'd4;
	localparam logic [2:0] KIND_BYTE    = 3'd5;

	// wire types placed in the low three tag bits
	localparam logic [2:0] WT_VARINT = 3'd0;
	localparam logic [2:0] WT_I64    = 3'd1;
	localparam logic [2:0] WT_LEN    = 3'd2;
	localparam logic [2:0] WT_I32    = 3'd5;

	localparam int TAG_W      = 35;
	localparam int TAG_BYTES  = 5;
	localparam int PAY_BYTES  = 10;
	localparam int GROUP_W    = 7;

	typedef enum logic [1:0] {
		PM_VARINT = 2'd0,
		PM_FIX32  = 2'd1,
		PM_FIX64  = 2'd2,
		PM_BYTE   = 2'd3
	} pay_mode_t;

	// after decode
	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [63:0]      pay;
		pay_mode_t        mode;
	} dec_t;

	// after sizing
	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [63:0]      pay;
		pay_mode_t        mode;
		logic [2:0]       tag_len;
		logic [3:0]       pay_len;
	} sized_t;

	// formatted wire bytes, lowest byte goes out first
	typedef struct packed {
		logic [8*TAG_BYTES-1:0] tag_bytes;
		logic [8*PAY_BYTES-1:0] pay_bytes;
		logic [2:0]             tag_len;
		logic [3:0]             pay_len;
	} fmt_t;

endpackage

`default_nettype wire

@@ rtl/pbfe_decode.sv @@
// stage 1: kind decode, tag build and zigzag mapping
// depends on pbfe_pkg
`default_nettype none

module pbfe_decode import pbfe_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  kind,
	input  wire logic [31:0] field_number,
	input  wire logic [63:0] value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output dec_t             out_data
);

	logic valid_s1;
	dec_t data_s1;
	dec_t dec;
	logic known;

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	always_comb begin
		dec.pay  = value;
		dec.tag  = {field_number, WT_VARINT};
		dec.mode = PM_VARINT;
		known    = 1'b1;
		case (kind)
			KIND_VARINT: begin
				dec.tag = {field_number, WT_VARINT};
			end
			KIND_SVARINT: begin
				dec.tag = {field_number, WT_VARINT};
				dec.pay = {value[62:0], 1'b0} ^ {64{value[63]}};
			end
			KIND_FIX32: begin
				dec.tag  = {field_number, WT_I32};
				dec.mode = PM_FIX32;
			end
			KIND_FIX64: begin
				dec.tag  = {field_number, WT_I64};
				dec.mode = PM_FIX64;
			end
			KIND_HEADER: begin
				dec.tag = {field_number, WT_LEN};
			end
			KIND_BYTE: begin
				dec.mode = PM_BYTE;
			end
			default: begin
				// unused kinds are swallowed
				known = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid && known;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= dec;
		end
	end

endmodule

`default_nettype wire

@@ rtl/pbfe_size.sv @@
// stage 2: byte counts of the tag and the payload
// depends on pbfe_pkg
`default_nettype none

module pbfe_size import pbfe_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  dec_t      in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output sized_t    out_data
);

	logic   valid_s2;
	sized_t data_s2;
	sized_t nxt;

	assign in_ready  = !valid_s2 || out_ready;
	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	always_comb begin
		nxt.tag     = in_data.tag;
		nxt.pay     = in_data.pay;
		nxt.mode    = in_data.mode;
		nxt.tag_len = 3'd1;
		nxt.pay_len = 4'd1;
		// highest nonzero 7-bit group sets the varint length
		for (int i = 1; i < TAG_BYTES; i++) begin
			if ((in_data.tag >> (GROUP_W * i)) != '0) begin
				nxt.tag_len = 3'(i + 1);
			end
		end
		for (int i = 1; i < PAY_BYTES; i++) begin
			if ((in_data.pay >> (GROUP_W * i)) != '0) begin
				nxt.pay_len = 4'(i + 1);
			end
		end
		case (in_data.mode)
			PM_VARINT: begin
			end
			PM_FIX32: begin
				nxt.pay_len = 4'd4;
			end
			PM_FIX64: begin
				nxt.pay_len = 4'd8;
			end
			PM_BYTE: begin
				nxt.tag_len = 3'd0;
				nxt.pay_len = 4'd1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2 <= nxt;
		end
	end

endmodule

`default_nettype wire

@@ rtl/pbfe_format.sv @@
// stage 3: lays out tag and payload wire bytes with continuation bits
// depends on pbfe_pkg
`default_nettype none

module pbfe_format import pbfe_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  sized_t    in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output fmt_t      out_data
);

	logic                           valid_s3;
	fmt_t                           data_s3;
	fmt_t                           nxt;
	logic [8*TAG_BYTES-1:0]         tag_ext;
	logic [GROUP_W*PAY_BYTES-1:0]   pay_ext;
	logic [8*PAY_BYTES-1:0]         pay_var;

	assign in_ready  = !valid_s3 || out_ready;
	assign out_valid = valid_s3;
	assign out_data  = data_s3;

	always_comb begin
		tag_ext = {5'd0, in_data.tag};
		pay_ext = {6'd0, in_data.pay};
		nxt.tag_len = in_data.tag_len;
		nxt.pay_len = in_data.pay_len;
		for (int i = 0; i < TAG_BYTES; i++) begin
			nxt.tag_bytes[8*i +: 8] = {3'(i + 1) < in_data.tag_len,
				tag_ext[GROUP_W*i +: GROUP_W]};
		end
		for (int i = 0; i < PAY_BYTES; i++) begin
			pay_var[8*i +: 8] = {4'(i + 1) < in_data.pay_len,
				pay_ext[GROUP_W*i +: GROUP_W]};
		end
		// fixed and raw bytes go out little-endian as they are
		if (in_data.mode == PM_VARINT) begin
			nxt.pay_bytes = pay_var;
		end else begin
			nxt.pay_bytes = {16'd0, in_data.pay};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s3 <= nxt;
		end
	end

endmodule

`default_nettype wire

@@ rtl/pbfe_serial.sv @@
// byte serializer: shifts out tag then payload bytes into the output register
// depends on pbfe_pkg
`default_nettype none

module pbfe_serial import pbfe_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  fmt_t            in_data,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,
	output logic            m_tlast
);

	logic                   busy_q;
	logic [8*TAG_BYTES-1:0] tag_q;
	logic [8*PAY_BYTES-1:0] pay_q;
	logic [2:0]             tcnt_q;
	logic [3:0]             pcnt_q;
	logic                   ovalid_q;
	logic [7:0]             obyte_q;
	logic                   olast_q;
	logic                   out_free;
	logic                   emit;
	logic                   emit_last;
	logic                   from_tag;
	logic                   load;

	assign out_free  = !ovalid_q || m_tready;
	assign emit      = busy_q && out_free;
	assign from_tag  = tcnt_q != 3'd0;
	assign emit_last = !from_tag && pcnt_q == 4'd1;
	// next item loads in the cycle the previous one emits its last byte
	assign in_ready  = !busy_q || (emit && emit_last);
	assign load      = in_valid && in_ready;

	assign m_tvalid = ovalid_q;
	assign m_tdata  = obyte_q;
	assign m_tlast  = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
			end else if (emit && emit_last) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tag_q  <= in_data.tag_bytes;
			pay_q  <= in_data.pay_bytes;
			tcnt_q <= in_data.tag_len;
			pcnt_q <= in_data.pay_len;
		end else if (emit) begin
			if (from_tag) begin
				tag_q  <= tag_q >> 8;
				tcnt_q <= tcnt_q - 3'd1;
			end else begin
				pay_q  <= pay_q >> 8;
				pcnt_q <= pcnt_q - 4'd1;
			end
		end
		if (emit) begin
			obyte_q <= from_tag ? tag_q[7:0] : pay_q[7:0];
			olast_q <= emit_last;
		end
	end

endmodule

`default_nettype wire

@@ rtl/protobuf_field_encoder.sv @@
// protobuf wire-format field encoder, top level
// depends on pbfe_pkg, pbfe_decode, pbfe_size, pbfe_format, pbfe_serial
//
//  channel  | dir | beat contents
//  ---------+-----+-----------------------------------------------
//  s_*      | in  | one field request: kind, field number, value
//  m_*      | out | one wire byte, tlast on the final byte of a request
//
// three register stages (decode, size, format) feed a serializer that sends one
// byte per cycle while m_tready is high; a request has 1 to 15 wire bytes, so
// the output port sets the rate. bytes pass each stage, then the serializer's
// shift and output registers. reset clears only valid and busy flags. a stall
// on m_tready backs up through every stage without dropping or repeating beats.
`default_nettype none

module protobuf_field_encoder import pbfe_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [95:0] s_tdata,  // field_number[31:0], value[95:32]
	input  wire logic [2:0]  s_tuser,  // kind[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // out_byte[7:0]
	output logic             m_tlast
);

	logic   v1, r1, v2, r2, v3, r3;
	dec_t   d1;
	sized_t d2;
	fmt_t   d3;

	pbfe_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.kind         (s_tuser),
		.field_number (s_tdata[31:0]),
		.value        (s_tdata[95:32]),
		.out_valid    (v1),
		.out_ready    (r1),
		.out_data     (d1)
	);

	pbfe_size u_size (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_ready  (r1),
		.in_data   (d1),
		.out_valid (v2),
		.out_ready (r2),
		.out_data  (d2)
	);

	pbfe_format u_format (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v2),
		.in_ready  (r2),
		.in_data   (d2),
		.out_valid (v3),
		.out_ready (r3),
		.out_data  (d3)
	);

	pbfe_serial u_serial (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v3),
		.in_ready (r3),
		.in_data  (d3),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire
